FILE: rtl/core/tdaf_pkg.sv
// ----------------------------------------------------------------------------
// tdaf_pkg
// Shared types and constants for the temperature dwell alarm controller.
// ----------------------------------------------------------------------------
package tdaf_pkg;

  localparam int TDAF_TIMER_WIDTH = 32;
  localparam int TEMP_W           = 12;
  localparam int DWELL_W          = 32;
  localparam int ELAPSED_W        = 16;
  localparam int CFG_ADDR_W       = 2;
  localparam int CFG_DATA_W       = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_PRE_THRESHOLD   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALARM_THRESHOLD = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PRE_DWELL       = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALARM_DWELL     = 2'd3;

  localparam logic [TEMP_W-1:0]  RST_PRE_THRESHOLD   = 12'd300;
  localparam logic [TEMP_W-1:0]  RST_ALARM_THRESHOLD = 12'd400;
  localparam logic [DWELL_W-1:0] RST_PRE_DWELL       = 32'd5000;
  localparam logic [DWELL_W-1:0] RST_ALARM_DWELL     = 32'd5000;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_PRE   = 2'd1;
  localparam logic [1:0] MODE_ALARM = 2'd2;

  localparam logic [2:0] FLAG_PRE   = 3'b001;
  localparam logic [2:0] FLAG_ALARM = 3'b010;
  localparam logic [2:0] FLAG_CMD   = 3'b100;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PRE   = 3'b010,
    ST_ALARM = 3'b100
  } state_t;

  typedef struct packed {
    logic [TEMP_W-1:0]  pre_threshold;
    logic [TEMP_W-1:0]  alarm_threshold;
    logic [DWELL_W-1:0] pre_dwell_ms;
    logic [DWELL_W-1:0] alarm_dwell_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       pre_alarm_on;
    logic       alarm_on;
    logic       commands_enabled;
    logic       reset_confirmed;
  } res_t;

endpackage

FILE: rtl/core/tdaf_cfg.sv
// ----------------------------------------------------------------------------
// tdaf_cfg
// Configuration register file: thresholds and dwell times.
// ----------------------------------------------------------------------------
module tdaf_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tdaf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tdaf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tdaf_pkg::cfg_t                 cfg
);
  import tdaf_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pre_threshold   <= RST_PRE_THRESHOLD;
      cfg_r.alarm_threshold <= RST_ALARM_THRESHOLD;
      cfg_r.pre_dwell_ms    <= RST_PRE_DWELL;
      cfg_r.alarm_dwell_ms  <= RST_ALARM_DWELL;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PRE_THRESHOLD:   cfg_r.pre_threshold   <= cfg_wdata[TEMP_W-1:0];
        CFG_ALARM_THRESHOLD: cfg_r.alarm_threshold <= cfg_wdata[TEMP_W-1:0];
        CFG_PRE_DWELL:       cfg_r.pre_dwell_ms    <= cfg_wdata[DWELL_W-1:0];
        CFG_ALARM_DWELL:     cfg_r.alarm_dwell_ms  <= cfg_wdata[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/tdaf_fsm.sv
// ----------------------------------------------------------------------------
// tdaf_fsm
// Mode state machine with entry actions and saturating dwell timers.
// ----------------------------------------------------------------------------
module tdaf_fsm #(
  parameter int TIMER_WIDTH = tdaf_pkg::TDAF_TIMER_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [tdaf_pkg::TEMP_W-1:0]    temperature,
  input  logic                          button_pressed,
  input  logic [tdaf_pkg::ELAPSED_W-1:0] elapsed_ms,
  input  tdaf_pkg::cfg_t                cfg,
  output tdaf_pkg::res_t                res
);
  import tdaf_pkg::*;

  localparam int CW = (TIMER_WIDTH > DWELL_W) ? TIMER_WIDTH : DWELL_W;

  state_t                 st_r, st_nxt;
  logic                   entry_r, entry_nxt;
  logic                   pre_run_r, pre_run_nxt;
  logic [TIMER_WIDTH-1:0] pre_tmr_r, pre_tmr_nxt;
  logic                   alm_run_r, alm_run_nxt;
  logic [TIMER_WIDTH-1:0] alm_tmr_r, alm_tmr_nxt;
  logic [2:0]             flags_r, flags_nxt;
  logic                   confirmed;
  logic                   ge_pre, ge_alarm;

  function automatic logic [TIMER_WIDTH-1:0] tmr_adv(
    input logic                   run,
    input logic [TIMER_WIDTH-1:0] t,
    input logic [ELAPSED_W-1:0]   el
  );
    logic [TIMER_WIDTH:0] s;
    s = {1'b0, t} + (TIMER_WIDTH+1)'(el);
    if (!run) tmr_adv = '0;
    else if (s[TIMER_WIDTH]) tmr_adv = '1;
    else tmr_adv = s[TIMER_WIDTH-1:0];
  endfunction

  function automatic logic [1:0] mode_code(input state_t s);
    case (s)
      ST_PRE:   mode_code = MODE_PRE;
      ST_ALARM: mode_code = MODE_ALARM;
      default:  mode_code = MODE_IDLE;
    endcase
  endfunction

  assign ge_pre   = $signed(temperature) >= $signed(cfg.pre_threshold);
  assign ge_alarm = $signed(temperature) >= $signed(cfg.alarm_threshold);

  always_comb begin
    st_nxt      = st_r;
    entry_nxt   = 1'b0;
    pre_run_nxt = pre_run_r;
    pre_tmr_nxt = pre_tmr_r;
    alm_run_nxt = alm_run_r;
    alm_tmr_nxt = alm_tmr_r;
    flags_nxt   = flags_r;
    confirmed   = 1'b0;
    case (st_r)
      ST_PRE: begin
        if (entry_r) begin
          pre_run_nxt = 1'b0;
          pre_tmr_nxt = '0;
          alm_run_nxt = 1'b0;
          alm_tmr_nxt = '0;
          flags_nxt   = (flags_nxt | FLAG_PRE) & ~FLAG_CMD;
        end
        if (!ge_pre) begin
          st_nxt    = ST_IDLE;
          entry_nxt = 1'b1;
        end else if (ge_alarm) begin
          alm_tmr_nxt = tmr_adv(alm_run_nxt, alm_tmr_nxt, elapsed_ms);
          alm_run_nxt = 1'b1;
          if (CW'(alm_tmr_nxt) >= CW'(cfg.alarm_dwell_ms)) begin
            st_nxt    = ST_ALARM;
            entry_nxt = 1'b1;
          end
        end else begin
          alm_run_nxt = 1'b0;
          alm_tmr_nxt = '0;
        end
      end
      ST_ALARM: begin
        if (entry_r) begin
          flags_nxt = (flags_nxt | FLAG_ALARM) & ~FLAG_CMD;
        end
        if (button_pressed) begin
          confirmed = 1'b1;
          st_nxt    = ST_IDLE;
          entry_nxt = 1'b1;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
        if (entry_r) begin
          pre_run_nxt = 1'b0;
          pre_tmr_nxt = '0;
          alm_run_nxt = 1'b0;
          alm_tmr_nxt = '0;
          flags_nxt   = FLAG_CMD;
        end
        if (ge_pre) begin
          pre_tmr_nxt = tmr_adv(pre_run_nxt, pre_tmr_nxt, elapsed_ms);
          pre_run_nxt = 1'b1;
          if (CW'(pre_tmr_nxt) >= CW'(cfg.pre_dwell_ms)) begin
            st_nxt    = ST_PRE;
            entry_nxt = 1'b1;
          end
        end else begin
          pre_run_nxt = 1'b0;
          pre_tmr_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      entry_r   <= 1'b1;
      pre_run_r <= 1'b0;
      pre_tmr_r <= '0;
      alm_run_r <= 1'b0;
      alm_tmr_r <= '0;
      flags_r   <= '0;
    end else if (step) begin
      st_r      <= st_nxt;
      entry_r   <= entry_nxt;
      pre_run_r <= pre_run_nxt;
      pre_tmr_r <= pre_tmr_nxt;
      alm_run_r <= alm_run_nxt;
      alm_tmr_r <= alm_tmr_nxt;
      flags_r   <= flags_nxt;
    end
  end

  assign res.mode             = mode_code(st_nxt);
  assign res.pre_alarm_on     = |(flags_nxt & FLAG_PRE);
  assign res.alarm_on         = |(flags_nxt & FLAG_ALARM);
  assign res.commands_enabled = |(flags_nxt & FLAG_CMD);
  assign res.reset_confirmed  = confirmed;

endmodule

FILE: rtl/core/temp_dwell_alarm_fsm_top.sv
// ----------------------------------------------------------------------------
// temp_dwell_alarm_fsm_top
// Three-mode temperature alarm controller with dwell timers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one transaction per periodic tick, carrying the
//   temperature sample, the button level and the milliseconds since the
//   previous tick. Output channel (out_*): exactly one transaction per tick
//   with the mode and indication flags after that tick.
//   Configuration port (cfg_*): write thresholds and dwell times while the
//   block is idle; writes take effect on the next edge.
//   Path: a tick accepted into the input register steps the state machine
//   between the input register and the result register, and its result is
//   captured in the result register that drives out_*. Throughput: one
//   tick per cycle while out_stall does not hold the result register.
//   Reset: mode idle, timers cleared, all flags low; the first tick runs
//   the idle entry actions. Configuration returns to its defaults.
//   Stall: a stalled result holds in the result register; the input
//   register still takes a tick while the result register is free or
//   moving, and in_stall rises only when both stages are full and blocked.
// ----------------------------------------------------------------------------
module temp_dwell_alarm_fsm_top #(
  parameter int TIMER_WIDTH = tdaf_pkg::TDAF_TIMER_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [tdaf_pkg::TEMP_W-1:0] in_temperature,
  input  logic                           in_button_pressed,
  input  logic [tdaf_pkg::ELAPSED_W-1:0]  in_elapsed_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_mode,
  output logic                           out_pre_alarm_on,
  output logic                           out_alarm_on,
  output logic                           out_commands_enabled,
  output logic                           out_reset_confirmed,
  input  logic                           cfg_we,
  input  logic [tdaf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tdaf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tdaf_pkg::*;

  cfg_t                 cfg;
  res_t                 res;
  res_t                 res_r;
  logic                 in_vld_r;
  logic                 out_vld_r;
  logic [TEMP_W-1:0]    temp_r;
  logic                 button_r;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic                 out_adv;
  logic                 step;
  logic                 in_take;

  assign out_adv  = ~out_vld_r | ~out_stall;
  assign step     = in_vld_r & out_adv;
  assign in_stall = in_vld_r & ~out_adv;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      temp_r    <= in_temperature;
      button_r  <= in_button_pressed;
      elapsed_r <= in_elapsed_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  tdaf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tdaf_fsm #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_fsm (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .temperature    (temp_r),
    .button_pressed (button_r),
    .elapsed_ms     (elapsed_r),
    .cfg            (cfg),
    .res            (res)
  );

  assign out_valid            = out_vld_r;
  assign out_mode             = res_r.mode;
  assign out_pre_alarm_on     = res_r.pre_alarm_on;
  assign out_alarm_on         = res_r.alarm_on;
  assign out_commands_enabled = res_r.commands_enabled;
  assign out_reset_confirmed  = res_r.reset_confirmed;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the temperature dwell alarm controller. Tick transactions are
// sent with random gaps while the result side stalls at random. A predictor
// tracks mode, dwell timers and indication flags, and every result is checked
// field by field against the oldest predicted status. Directed ticks walk the
// default thresholds and the configuration extremes, then random phases with
// fresh settings drive heat-up, alarm and button sequences mixed with noise.
// ----------------------------------------------------------------------------
module tb_top;
  import tdaf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [63:0] TIMER_MAX = {64{1'b1}} >> (64 - TDAF_TIMER_WIDTH);
  localparam int TEMP_MIN = -550;
  localparam int TEMP_MAX = 1500;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [TEMP_W-1:0] in_temperature = '0;
  logic                    in_button_pressed = 1'b0;
  logic [ELAPSED_W-1:0]    in_elapsed_ms = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [1:0]              out_mode;
  logic                    out_pre_alarm_on;
  logic                    out_alarm_on;
  logic                    out_commands_enabled;
  logic                    out_reset_confirmed;
  logic                    cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  temp_dwell_alarm_fsm_top u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_temperature       (in_temperature),
    .in_button_pressed    (in_button_pressed),
    .in_elapsed_ms        (in_elapsed_ms),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_mode             (out_mode),
    .out_pre_alarm_on     (out_pre_alarm_on),
    .out_alarm_on         (out_alarm_on),
    .out_commands_enabled (out_commands_enabled),
    .out_reset_confirmed  (out_reset_confirmed),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted controller state and settings
  logic signed [TEMP_W-1:0] pre_thr;
  logic signed [TEMP_W-1:0] alm_thr;
  logic [DWELL_W-1:0]       pre_dwell;
  logic [DWELL_W-1:0]       alm_dwell;
  logic [1:0]               tick_mode;
  bit                       first_tick_in_mode;
  bit                       pre_run;
  logic [63:0]              pre_ms;
  bit                       alm_run;
  logic [63:0]              alm_ms;
  logic [2:0]               ind_flags;

  res_t status_due[$];
  int   error_count = 0;
  int   cycle_count = 0;
  bit   quiet = 1'b0;
  int   zone = 0;
  int   zone_left = 0;
  int   stall_left = 0;

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [TEMP_W-1:0] pick_temp(int lo, int hi);
    if (lo < TEMP_MIN) lo = TEMP_MIN;
    if (hi > TEMP_MAX) hi = TEMP_MAX;
    if (lo > hi) begin
      lo = TEMP_MIN;
      hi = TEMP_MAX;
    end
    return TEMP_W'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  function automatic logic [DWELL_W-1:0] pick_dwell();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom();
      default: return $urandom_range(0, 3000);
    endcase
  endfunction

  function automatic void clear_timers();
    pre_run = 1'b0;
    pre_ms  = '0;
    alm_run = 1'b0;
    alm_ms  = '0;
  endfunction

  function automatic bit advance_dwell(inout bit running, inout logic [63:0] ms,
                                       input logic [ELAPSED_W-1:0] el,
                                       input logic [DWELL_W-1:0] dwell);
    if (!running) begin
      running = 1'b1;
      ms = '0;
    end else if (ms > TIMER_MAX - 64'(el)) begin
      ms = TIMER_MAX;
    end else begin
      ms = ms + 64'(el);
    end
    return ms >= 64'(dwell);
  endfunction

  function automatic res_t next_status(logic signed [TEMP_W-1:0] t, bit btn,
                                       logic [ELAPSED_W-1:0] el);
    res_t r;
    bit   entering;
    bit   confirmed;
    entering = first_tick_in_mode;
    first_tick_in_mode = 1'b0;
    confirmed = 1'b0;
    case (tick_mode)
      MODE_PRE: begin
        if (entering) begin
          clear_timers();
          ind_flags = (ind_flags | FLAG_PRE) & ~FLAG_CMD;
        end
        if (t < pre_thr) begin
          tick_mode = MODE_IDLE;
          first_tick_in_mode = 1'b1;
        end else if (t >= alm_thr) begin
          if (advance_dwell(alm_run, alm_ms, el, alm_dwell)) begin
            tick_mode = MODE_ALARM;
            first_tick_in_mode = 1'b1;
          end
        end else begin
          alm_run = 1'b0;
          alm_ms  = '0;
        end
      end
      MODE_ALARM: begin
        if (entering) ind_flags = (ind_flags | FLAG_ALARM) & ~FLAG_CMD;
        if (btn) begin
          confirmed = 1'b1;
          tick_mode = MODE_IDLE;
          first_tick_in_mode = 1'b1;
        end
      end
      default: begin
        tick_mode = MODE_IDLE;
        if (entering) begin
          clear_timers();
          ind_flags = FLAG_CMD;
        end
        if (t >= pre_thr) begin
          if (advance_dwell(pre_run, pre_ms, el, pre_dwell)) begin
            tick_mode = MODE_PRE;
            first_tick_in_mode = 1'b1;
          end
        end else begin
          pre_run = 1'b0;
          pre_ms  = '0;
        end
      end
    endcase
    r.mode             = tick_mode;
    r.pre_alarm_on     = |(ind_flags & FLAG_PRE);
    r.alarm_on         = |(ind_flags & FLAG_ALARM);
    r.commands_enabled = |(ind_flags & FLAG_CMD);
    r.reset_confirmed  = confirmed;
    return r;
  endfunction

  task automatic log_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  task automatic send_tick(logic signed [TEMP_W-1:0] t, bit btn, logic [ELAPSED_W-1:0] el);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_temperature    <= t;
    in_button_pressed <= btn;
    in_elapsed_ms     <= el;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    status_due.push_back(next_status(t, btn, el));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      CFG_PRE_THRESHOLD:   pre_thr   = data[TEMP_W-1:0];
      CFG_ALARM_THRESHOLD: alm_thr   = data[TEMP_W-1:0];
      CFG_PRE_DWELL:       pre_dwell = data;
      CFG_ALARM_DWELL:     alm_dwell = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_config(logic signed [TEMP_W-1:0] pt, logic signed [TEMP_W-1:0] at,
                              logic [DWELL_W-1:0] pd, logic [DWELL_W-1:0] ad);
    wait_drained();
    write_reg(CFG_PRE_THRESHOLD, {20'($urandom()), pt});
    write_reg(CFG_ALARM_THRESHOLD, {20'($urandom()), at});
    write_reg(CFG_PRE_DWELL, pd);
    write_reg(CFG_ALARM_DWELL, ad);
  endtask

  // one tick drawn from temperature segments: cold, warm, hot or noise
  task automatic random_tick();
    int hot;
    int span;
    logic signed [TEMP_W-1:0] t;
    logic [ELAPSED_W-1:0] el;
    if (zone_left == 0) begin
      zone = $urandom_range(0, 3);
      zone_left = $urandom_range(2, 12);
    end
    zone_left--;
    hot = (int'(alm_thr) > int'(pre_thr)) ? int'(alm_thr) : int'(pre_thr);
    case (zone)
      0: t = pick_temp(TEMP_MIN, int'(pre_thr) - 1);
      1: t = pick_temp(int'(pre_thr), int'(alm_thr) - 1);
      2: t = pick_temp(hot, TEMP_MAX);
      default: t = pick_temp(TEMP_MIN, TEMP_MAX);
    endcase
    span = (alm_dwell > 32'd120000 && pre_dwell > 32'd120000) ? 65535 :
           int'(((pre_dwell < alm_dwell) ? pre_dwell : alm_dwell) / 2 + 1);
    case ($urandom_range(0, 9))
      0: el = '0;
      1: el = '1;
      2: el = ELAPSED_W'($urandom());
      default: el = ELAPSED_W'($urandom_range(0, span));
    endcase
    send_tick(t, ($urandom_range(0, 5) == 0), el);
  endtask

  task automatic test_default_walk();
    send_tick(-550, 1'b0, 16'd0);
    send_tick(299, 1'b1, 16'hFFFF);
    send_tick(300, 1'b0, 16'hFFFF);
    send_tick(300, 1'b0, 16'd4999);
    send_tick(1500, 1'b1, 16'd1);
    send_tick(399, 1'b1, 16'd0);
    send_tick(400, 1'b0, 16'hFFFF);
    send_tick(300, 1'b0, 16'd100);
    send_tick(400, 1'b0, 16'd0);
    send_tick(1500, 1'b0, 16'd5000);
    send_tick(1500, 1'b0, 16'd0);
    send_tick(-550, 1'b0, 16'd0);
    send_tick(0, 1'b1, 16'd0);
    send_tick(0, 1'b0, 16'd0);
    send_tick(350, 1'b0, 16'd0);
    send_tick(200, 1'b0, 16'd0);
  endtask

  task automatic test_config_extremes();
    apply_config(-550, 1500, '0, '0);
    send_tick(-550, 1'b0, 16'd0);
    send_tick(1499, 1'b0, 16'd7);
    send_tick(1500, 1'b0, 16'd0);
    send_tick(1500, 1'b1, 16'd0);
    send_tick(-550, 1'b1, 16'hFFFF);
    apply_config(1500, -550, '1, '1);
    send_tick(1500, 1'b0, 16'hFFFF);
    send_tick(1500, 1'b0, 16'hFFFF);
    send_tick(1499, 1'b0, 16'hFFFF);
    apply_config(200, 100, '0, '0);
    send_tick(200, 1'b0, 16'd0);
    send_tick(150, 1'b0, 16'd0);
    send_tick(250, 1'b0, 16'd0);
    send_tick(250, 1'b0, 16'd0);
    send_tick(250, 1'b0, 16'd0);
  endtask

  task automatic test_random_phases();
    logic signed [TEMP_W-1:0] pt;
    logic signed [TEMP_W-1:0] at;
    for (int phase = 0; phase < 5; phase++) begin
      pt = pick_temp(TEMP_MIN, TEMP_MAX);
      at = ($urandom_range(0, 3) != 0) ? pick_temp(int'(pt), TEMP_MAX) :
                                         pick_temp(TEMP_MIN, TEMP_MAX);
      apply_config(pt, at, pick_dwell(), pick_dwell());
      for (int i = 0; i < 90; i++) begin
        if (i == 45 && phase == 1) wait_drained();
        random_tick();
      end
    end
  endtask

  task automatic test_quiet_stream();
    apply_config(RST_PRE_THRESHOLD, RST_ALARM_THRESHOLD, 32'd300, 32'd300);
    quiet = 1'b1;
    for (int i = 0; i < 40; i++) random_tick();
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin : stall_gen
    int n;
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      n = pick_gap();
      out_stall <= (n > 0);
      stall_left = (n > 0) ? n - 1 : $urandom_range(0, 4);
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        log_mismatch("result with nothing pending, mode", out_mode, -1);
      end else begin
        want = status_due.pop_front();
        if (out_mode !== want.mode) log_mismatch("mode", out_mode, want.mode);
        if (out_pre_alarm_on !== want.pre_alarm_on)
          log_mismatch("pre_alarm_on", out_pre_alarm_on, want.pre_alarm_on);
        if (out_alarm_on !== want.alarm_on)
          log_mismatch("alarm_on", out_alarm_on, want.alarm_on);
        if (out_commands_enabled !== want.commands_enabled)
          log_mismatch("commands_enabled", out_commands_enabled, want.commands_enabled);
        if (out_reset_confirmed !== want.reset_confirmed)
          log_mismatch("reset_confirmed", out_reset_confirmed, want.reset_confirmed);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    pre_thr            = RST_PRE_THRESHOLD;
    alm_thr            = RST_ALARM_THRESHOLD;
    pre_dwell          = RST_PRE_DWELL;
    alm_dwell          = RST_ALARM_DWELL;
    tick_mode          = MODE_IDLE;
    first_tick_in_mode = 1'b1;
    clear_timers();
    ind_flags          = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_walk();
    test_config_extremes();
    test_random_phases();
    test_quiet_stream();

    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
